// File: sv/lsb_stego_stream_decoder_defines.svh
// Assertion macros shared by the checker of the LSB stego stream decoder.
// Depends on nothing; included by files that assert.
`ifndef LSB_STEGO_STREAM_DECODER_DEFINES_SVH
`define LSB_STEGO_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LSBSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsbsd assertion failed");

// Next-cycle implication, disabled in reset.
`define LSBSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsbsd assertion failed");

`endif

// File: sv/lsbsd_pkg.sv
// Shared constants and types of the LSB stego stream decoder.
// Depends on nothing.
package lsbsd_pkg;

    localparam int PIXEL_W     = 8;
    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 3;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD   = 2'd1;

    localparam logic [CFG_W-1:0] HEADER_BYTES_RST = 16'd54;
    localparam logic [CFG_W-1:0] MAGIC_WORD_RST   = 16'd0;

    localparam logic [KIND_W-1:0] KIND_EXTLEN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXTCHAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLEN   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAYBYTE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MISMATCH = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic [KIND_W-1:0]  kind;
        logic               last;
    } res_t;

endpackage

// File: sv/lsbsd_pixel_if.sv
// Input channel of the decoder: one image byte per transfer.
// Depends on lsbsd_pkg.
interface lsbsd_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [lsbsd_pkg::PIXEL_W-1:0]   pixel_byte;
    logic                            start_of_image;

    modport source (output valid, output pixel_byte, output start_of_image, input ready);
    modport sink   (input valid, input pixel_byte, input start_of_image, output ready);
endinterface

// File: sv/lsbsd_field_if.sv
// Output channel of the decoder: one decoded field per transfer.
// Depends on lsbsd_pkg.
interface lsbsd_field_if;
    logic                            valid;
    logic                            ready;
    logic [lsbsd_pkg::VALUE_W-1:0]   value;
    logic [lsbsd_pkg::KIND_W-1:0]    kind;
    logic                            last;

    modport source (output valid, output value, output kind, output last, input ready);
    modport sink   (input valid, input value, input kind, input last, output ready);
endinterface

// File: sv/lsb_stego_stream_decoder.sv
// LSB stego stream decoder: takes one image byte per cycle, sustained, and
// emits each decoded field via the input register, then the result buffer.
// The single-pass frame parser between the input register and the two-entry
// result buffer sets that rate; the byte channel stalls only while both buffer
// entries are held by a stalled sink.
// Configuration writes (header_bytes, magic_word) belong to idle periods; a new
// header_bytes value applies from the next start of image.
module lsb_stego_stream_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsbsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsbsd_pkg::CFG_W-1:0]         cfg_data,
    lsbsd_pixel_if.sink                         pixels,
    lsbsd_field_if.source                       fields
);

    lsbsd_pkg::res_t res;
    logic            out_space;

    lsbsd_frame u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .out_space (out_space),
        .res       (res)
    );

    lsbsd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_space (out_space),
        .fields    (fields)
    );

endmodule

// File: sv/lsbsd_frame.sv
// Input register, configuration registers and frame parser of the decoder.
// Depends on lsbsd_pkg and lsbsd_pixel_if.
module lsbsd_frame
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsbsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsbsd_pkg::CFG_W-1:0]         cfg_data,
    lsbsd_pixel_if.sink                         pixels,
    input  logic                                out_space,
    output lsbsd_pkg::res_t                     res
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_MAGIC  = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_EXT    = 3'd3;
    localparam logic [2:0] PH_PAYLEN = 3'd4;
    localparam logic [2:0] PH_PAY    = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam int VW = lsbsd_pkg::VALUE_W;

    logic [lsbsd_pkg::CFG_W-1:0] header_bytes_reg;
    logic [lsbsd_pkg::CFG_W-1:0] magic_word_reg;

    logic in_valid_reg, in_valid_next;
    logic in_bit_reg;
    logic in_sof_reg;

    logic [2:0]    phase_reg, phase_next;
    logic [15:0]   header_left_reg, header_left_next;
    logic [4:0]    bit_count_reg, bit_count_next;
    logic [VW-1:0] shift_reg, shift_next;
    logic [VW-1:0] items_left_reg, items_left_next;

    logic          accept;
    logic          fire;
    logic [2:0]    ph;
    logic [2:0]    ph_eff;
    logic [15:0]   hl;
    logic [4:0]    bc;
    logic [VW-1:0] sb;
    logic [VW-1:0] il;
    logic [VW-1:0] il_dec;
    logic [VW-1:0] sb_shift;
    logic [5:0]    bc_inc;
    logic [5:0]    width;
    logic          field_done;
    logic          len_pos;

    assign fire          = in_valid_reg & out_space;
    assign pixels.ready  = ~in_valid_reg | out_space;
    assign accept        = pixels.valid & pixels.ready;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_comb
    begin
        // start of image restarts the frame on this same byte
        ph = in_sof_reg ? PH_HEADER : phase_reg;
        hl = in_sof_reg ? header_bytes_reg : header_left_reg;
        bc = in_sof_reg ? 5'd0 : bit_count_reg;
        sb = in_sof_reg ? '0 : shift_reg;
        il = in_sof_reg ? '0 : items_left_reg;

        ph_eff     = (ph == PH_HEADER) ? PH_MAGIC : ph;
        sb_shift   = {sb[VW-2:0], in_bit_reg};
        bc_inc     = {1'b0, bc} + 6'd1;
        il_dec     = il - {{(VW-1){1'b0}}, 1'b1};
        len_pos    = (sb_shift != '0) & ~sb_shift[VW-1];

        case (ph_eff)
            PH_MAGIC:             width = 6'd16;
            PH_EXTLEN, PH_PAYLEN: width = 6'd32;
            default:              width = 6'd8;
        endcase
        field_done = (bc_inc >= width);

        phase_next       = phase_reg;
        header_left_next = header_left_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        items_left_next  = items_left_reg;
        res              = '0;

        if (fire)
        begin
            phase_next       = ph;
            header_left_next = hl;
            bit_count_next   = bc;
            shift_next       = sb;
            items_left_next  = il;
            if (ph == PH_HEADER && hl != 16'd0)
            begin
                header_left_next = hl - 16'd1;
            end
            else if (ph_eff == PH_DONE || ph_eff == 3'd7)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                phase_next = ph_eff;
                if (!field_done)
                begin
                    shift_next     = sb_shift;
                    bit_count_next = bc_inc[4:0];
                end
                else
                begin
                    shift_next     = '0;
                    bit_count_next = 5'd0;
                    res.valid      = 1'b1;
                    case (ph_eff)
                        PH_MAGIC:
                        begin
                            res.value = {16'd0, sb_shift[15:0]};
                            res.kind  = lsbsd_pkg::KIND_MISMATCH;
                            res.last  = 1'b1;
                            if (sb_shift[15:0] != magic_word_reg)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_EXTLEN;
                                res.valid  = 1'b0;
                            end
                        end
                        PH_EXTLEN:
                        begin
                            res.value       = sb_shift;
                            res.kind        = lsbsd_pkg::KIND_EXTLEN;
                            items_left_next = len_pos ? sb_shift : '0;
                            phase_next      = len_pos ? PH_EXT : PH_PAYLEN;
                        end
                        PH_EXT:
                        begin
                            res.value       = {24'd0, sb_shift[7:0]};
                            res.kind        = lsbsd_pkg::KIND_EXTCHAR;
                            items_left_next = il_dec;
                            if (il_dec == '0)
                                phase_next = PH_PAYLEN;
                        end
                        PH_PAYLEN:
                        begin
                            res.value       = sb_shift;
                            res.kind        = lsbsd_pkg::KIND_PAYLEN;
                            res.last        = ~len_pos;
                            items_left_next = len_pos ? sb_shift : '0;
                            phase_next      = len_pos ? PH_PAY : PH_DONE;
                        end
                        default:
                        begin
                            res.value       = {24'd0, sb_shift[7:0]};
                            res.kind        = lsbsd_pkg::KIND_PAYBYTE;
                            res.last        = (il_dec == '0);
                            items_left_next = il_dec;
                            if (il_dec == '0)
                                phase_next = PH_DONE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg <= lsbsd_pkg::HEADER_BYTES_RST;
            magic_word_reg   <= lsbsd_pkg::MAGIC_WORD_RST;
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_HEADER;
            header_left_reg  <= lsbsd_pkg::HEADER_BYTES_RST;
            bit_count_reg    <= 5'd0;
            shift_reg        <= '0;
            items_left_reg   <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == lsbsd_pkg::CFG_HEADER_BYTES)
                header_bytes_reg <= cfg_data;
            if (cfg_we && cfg_index == lsbsd_pkg::CFG_MAGIC_WORD)
                magic_word_reg <= cfg_data;
            in_valid_reg    <= in_valid_next;
            phase_reg       <= phase_next;
            header_left_reg <= header_left_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            items_left_reg  <= items_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_bit_reg <= pixels.pixel_byte[0];
            in_sof_reg <= pixels.start_of_image;
        end
    end

endmodule

// File: sv/lsbsd_out_buf.sv
// Two-entry result buffer that drives the field channel.
// Depends on lsbsd_pkg and lsbsd_field_if.
module lsbsd_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  lsbsd_pkg::res_t   res,
    output logic              out_space,
    lsbsd_field_if.source     fields
);

    logic [1:0]      count_reg, count_next;
    lsbsd_pkg::res_t head_reg, head_next;
    lsbsd_pkg::res_t skid_reg, skid_next;
    logic            push;
    logic            pop;

    assign push      = res.valid;
    assign pop       = fields.valid & fields.ready;
    assign out_space = (count_reg != 2'd2);

    assign fields.valid = (count_reg != 2'd0);
    assign fields.value = head_reg.value;
    assign fields.kind  = head_reg.kind;
    assign fields.last  = head_reg.last;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        case ({push, pop})
            2'b11:
            begin
                if (count_reg == 2'd2)
                begin
                    head_next = skid_reg;
                    skid_next = res;
                end
                else
                begin
                    head_next = res;
                end
            end
            2'b01:
            begin
                head_next  = skid_reg;
                count_next = count_reg - 2'd1;
            end
            2'b10:
            begin
                if (count_reg == 2'd0)
                    head_next = res;
                else
                    skid_next = res;
                count_next = count_reg + 2'd1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// File: sv/lsbsd_checker.sv
// Port-level checks of the LSB stego stream decoder, bound to the top level.
// Depends on lsbsd_pkg and the assertion macro header.
`include "lsb_stego_stream_decoder_defines.svh"

module lsbsd_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [lsbsd_pkg::VALUE_W-1:0]     out_value,
    input logic [lsbsd_pkg::KIND_W-1:0]      out_kind,
    input logic                              out_last
);

    logic stalled;
    logic is_mismatch;
    logic is_ext;

    assign stalled     = out_valid & ~out_ready;
    assign is_mismatch = out_valid & (out_kind == lsbsd_pkg::KIND_MISMATCH);
    assign is_ext      = out_valid & ((out_kind == lsbsd_pkg::KIND_EXTLEN)
                                   || (out_kind == lsbsd_pkg::KIND_EXTCHAR));

    // a stalled result holds
    `LSBSD_ASSERT_NXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(out_value) && $stable(out_kind) && $stable(out_last))
    // magic mismatch always ends the frame
    `LSBSD_ASSERT_IMP(a_mismatch_last, clk, rst_n, is_mismatch, out_last)
    // the mismatch carries only the sixteen magic bits
    `LSBSD_ASSERT_IMP(a_mismatch_value, clk, rst_n, is_mismatch, out_value[31:16] == 16'd0)
    // extension fields never close a frame
    `LSBSD_ASSERT_IMP(a_ext_not_last, clk, rst_n, is_ext, !out_last)

endmodule

bind lsb_stego_stream_decoder lsbsd_checker u_lsbsd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (fields.valid),
    .out_ready (fields.ready),
    .out_value (fields.value),
    .out_kind  (fields.kind),
    .out_last  (fields.last)
);

// File: bench/lsb_stego_stream_decoder_tb.sv
// Testbench for lsb_stego_stream_decoder: streams stego images through the byte channel
// and checks every decoded field against a cycle-free predictor held in a scoreboard class.
// Depends on lsbsd_pkg, lsbsd_pixel_if, lsbsd_field_if and the decoder RTL.
`timescale 1ns / 100ps

module lsb_stego_stream_decoder_tb;

    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS  = 60;

    // indexes past the register list; writes there are dropped
    localparam logic [lsbsd_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [lsbsd_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef logic [lsbsd_pkg::PIXEL_W-1:0] pixel_t;

    typedef enum logic [2:0] {
        DEC_HEADER,
        DEC_MAGIC,
        DEC_EXTLEN,
        DEC_EXT,
        DEC_PAYLEN,
        DEC_PAY,
        DEC_DONE
    } dec_phase_t;

    typedef struct packed {
        logic [lsbsd_pkg::VALUE_W-1:0] value;
        logic [lsbsd_pkg::KIND_W-1:0]  kind;
        logic                          last;
    } field_t;

    class field_scoreboard;
        field_t                      pending[$];
        int unsigned                 errors;
        logic [lsbsd_pkg::CFG_W-1:0] header_cfg;
        logic [lsbsd_pkg::CFG_W-1:0] magic_cfg;
        dec_phase_t                  phase;
        logic [15:0]                 header_left;
        logic [4:0]                  nbits;
        logic [31:0]                 acc;
        logic [31:0]                 remaining;

        function new();
            errors      = 0;
            header_cfg  = lsbsd_pkg::HEADER_BYTES_RST;
            magic_cfg   = lsbsd_pkg::MAGIC_WORD_RST;
            phase       = DEC_HEADER;
            header_left = lsbsd_pkg::HEADER_BYTES_RST;
            nbits       = '0;
            acc         = '0;
            remaining   = '0;
        endfunction

        function void write_reg(logic [lsbsd_pkg::CFG_INDEX_W-1:0] idx,
                                logic [lsbsd_pkg::CFG_W-1:0] data);
            if (idx == lsbsd_pkg::CFG_HEADER_BYTES)
                header_cfg = data;
            else if (idx == lsbsd_pkg::CFG_MAGIC_WORD)
                magic_cfg = data;
        endfunction

        function bit shift_in(bit b, int unsigned width);
            acc = {acc[30:0], b};
            if (int'(nbits) + 1 >= width)
            begin
                nbits = '0;
                return 1'b1;
            end
            nbits = nbits + 5'd1;
            return 1'b0;
        endfunction

        function void push(logic [31:0] v, logic [lsbsd_pkg::KIND_W-1:0] k, logic l);
            field_t f;
            f.value = v;
            f.kind  = k;
            f.last  = l;
            pending.push_back(f);
        endfunction

        // Returns 0 when the byte lands in a finished frame and is simply dropped.
        function bit note_pixel(pixel_t pb, logic sop);
            logic [31:0] w;
            bit          b;
            b = pb[0];
            if (sop)
            begin
                phase       = DEC_HEADER;
                header_left = header_cfg;
                nbits       = '0;
                acc         = '0;
                remaining   = '0;
            end
            if (phase == DEC_DONE)
                return 1'b0;
            if (phase == DEC_HEADER)
            begin
                if (header_left != 0)
                begin
                    header_left = header_left - 16'd1;
                    return 1'b1;
                end
                // this byte already carries the first hidden bit
                phase = DEC_MAGIC;
                acc   = '0;
                nbits = '0;
            end
            case (phase)
                DEC_MAGIC:
                    if (shift_in(b, 16))
                    begin
                        w   = {16'd0, acc[15:0]};
                        acc = '0;
                        if (w[15:0] != magic_cfg)
                        begin
                            phase = DEC_DONE;
                            push(w, lsbsd_pkg::KIND_MISMATCH, 1'b1);
                        end
                        else
                            phase = DEC_EXTLEN;
                    end
                DEC_EXTLEN:
                    if (shift_in(b, 32))
                    begin
                        w   = acc;
                        acc = '0;
                        if (w != 0 && !w[31])
                        begin
                            remaining = w;
                            phase     = DEC_EXT;
                        end
                        else
                        begin
                            remaining = '0;
                            phase     = DEC_PAYLEN;
                        end
                        push(w, lsbsd_pkg::KIND_EXTLEN, 1'b0);
                    end
                DEC_EXT:
                    if (shift_in(b, 8))
                    begin
                        w         = {24'd0, acc[7:0]};
                        acc       = '0;
                        remaining = remaining - 32'd1;
                        if (remaining == 0)
                            phase = DEC_PAYLEN;
                        push(w, lsbsd_pkg::KIND_EXTCHAR, 1'b0);
                    end
                DEC_PAYLEN:
                    if (shift_in(b, 32))
                    begin
                        w   = acc;
                        acc = '0;
                        if (w != 0 && !w[31])
                        begin
                            remaining = w;
                            phase     = DEC_PAY;
                            push(w, lsbsd_pkg::KIND_PAYLEN, 1'b0);
                        end
                        else
                        begin
                            remaining = '0;
                            phase     = DEC_DONE;
                            push(w, lsbsd_pkg::KIND_PAYLEN, 1'b1);
                        end
                    end
                DEC_PAY:
                    if (shift_in(b, 8))
                    begin
                        w         = {24'd0, acc[7:0]};
                        acc       = '0;
                        remaining = remaining - 32'd1;
                        if (remaining == 0)
                        begin
                            phase = DEC_DONE;
                            push(w, lsbsd_pkg::KIND_PAYBYTE, 1'b1);
                        end
                        else
                            push(w, lsbsd_pkg::KIND_PAYBYTE, 1'b0);
                    end
                default:
                    phase = DEC_DONE;
            endcase
            return 1'b1;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_field(logic [lsbsd_pkg::VALUE_W-1:0] v, logic [lsbsd_pkg::KIND_W-1:0] k,
                         logic l);
            field_t exp_f;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected field value=%h kind=%0d last=%0b", v, k, l));
                return;
            end
            exp_f = pending.pop_front();
            if (v !== exp_f.value)
                report($sformatf("value %h, expected %h", v, exp_f.value));
            if (k !== exp_f.kind)
                report($sformatf("kind %0d, expected %0d", k, exp_f.kind));
            if (l !== exp_f.last)
                report($sformatf("last %0b, expected %0b", l, exp_f.last));
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [lsbsd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lsbsd_pkg::CFG_W-1:0]       cfg_data;

    lsbsd_pixel_if pixels();
    lsbsd_field_if fields();

    lsb_stego_stream_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .fields    (fields)
    );

    field_scoreboard sb;
    bit              bits_q[$];
    bit              quiet;
    bit              force_quiet;
    int unsigned     active_items;
    int unsigned     stall_left;
    int unsigned     cycles;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (quiet || force_quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sink side: check on transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (fields.valid && fields.ready)
                sb.check_field(fields.value, fields.kind, fields.last);
            if (stall_left != 0)
            begin
                stall_left--;
                fields.ready <= 1'b0;
            end
            else
            begin
                fields.ready <= 1'b1;
                stall_left = idle_cycles();
            end
        end
    end

    task automatic send_pixel(input pixel_t pb, input logic sop);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0)
        begin
            pixels.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixels.valid          <= 1'b1;
        pixels.pixel_byte     <= pb;
        pixels.start_of_image <= sop;
        @(posedge clk);
        while (!pixels.ready)
            @(posedge clk);
        void'(sb.note_pixel(pb, sop));
        active_items++;
    endtask

    function automatic void push_field(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            bits_q.push_back(v[i]);
    endfunction

    // header bytes first, then one hidden bit per byte; sop on the very first byte
    task automatic send_image(input int unsigned hdr_len);
        int unsigned k;
        bit          first;
        first = 1'b1;
        quiet = ($urandom_range(4) == 0);
        for (k = 0; k < hdr_len; k++)
        begin
            send_pixel(pixel_t'($urandom()), first);
            first = 1'b0;
        end
        for (k = 0; k < bits_q.size(); k++)
        begin
            send_pixel({7'($urandom()), bits_q[k]}, first);
            first = 1'b0;
        end
        bits_q.delete();
    endtask

    task automatic drain();
        pixels.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [lsbsd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lsbsd_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [lsbsd_pkg::CFG_W-1:0] hdr,
                                  input logic [lsbsd_pkg::CFG_W-1:0] mw,
                                  input bit [1:0] which);
        drain();
        if (which[0])
            put_reg(lsbsd_pkg::CFG_HEADER_BYTES, hdr);
        if (which[1])
            put_reg(lsbsd_pkg::CFG_MAGIC_WORD, mw);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_len(input int unsigned max_small);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom_range(1, max_small);
        if (r < 65)
            return 32'd0;
        if (r < 80)
            return {1'b1, 31'($urandom())};
        if (r < 88)
            return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'hFFFF_FFFF;
        // long positive length, the frame gets cut by the next image
        return {1'b0, 31'($urandom())} | 32'h0000_0100;
    endfunction

    task automatic random_image();
        int unsigned r;
        int unsigned k;
        int unsigned cut;
        logic [15:0] m;
        logic [31:0] el;
        logic [31:0] pl;
        logic [31:0] n_items;
        r = $urandom_range(99);
        if (r < 10)
        begin
            repeat ($urandom_range(1, 120)) bits_q.push_back(1'($urandom()));
        end
        else
        begin
            m = sb.magic_cfg;
            if (r < 16)
                m = m ^ (16'd1 << $urandom_range(15));
            else if (r < 20)
                m = 16'($urandom());
            push_field({16'd0, m}, 16);
            el = pick_len(3);
            n_items = (el != 0 && !el[31]) ? el : 32'd0;
            push_field(el, 32);
            for (k = 0; k < n_items && k < 4; k++)
                push_field($urandom(), 8);
            if (n_items <= 4)
            begin
                pl = pick_len(8);
                n_items = (pl != 0 && !pl[31]) ? pl : 32'd0;
                push_field(pl, 32);
                for (k = 0; k < n_items && k < 10; k++)
                    push_field($urandom(), 8);
            end
            if ($urandom_range(9) == 0)
            begin
                cut = $urandom_range(1, bits_q.size() - 1);
                repeat (cut) void'(bits_q.pop_back());
            end
            repeat ($urandom_range(0, 6)) bits_q.push_back(1'($urandom()));
        end
        send_image(sb.header_cfg);
    endtask

    initial
    begin
        int unsigned                 goal;
        logic [lsbsd_pkg::CFG_W-1:0] hdr;
        logic [lsbsd_pkg::CFG_W-1:0] mw;
        bit [1:0]                    which;

        sb                    = new();
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        pixels.valid          = 1'b0;
        pixels.pixel_byte     = '0;
        pixels.start_of_image = 1'b0;
        fields.ready          = 1'b0;
        quiet                 = 1'b0;
        force_quiet           = 1'b0;
        active_items          = 0;
        stall_left            = 0;
        cycles                = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 54-byte header, magic 0; spare indexes must not disturb them
        put_reg(CFG_SPARE_A, 16'h0000);
        put_reg(CFG_SPARE_B, 16'hFFFF);
        cfg_we <= 1'b0;
        push_field(32'h0, 16);
        push_field(32'h0, 32);
        push_field(32'h0, 32);
        send_image(sb.header_cfg);
        push_field(32'h0, 16);
        push_field(32'd1, 32);
        push_field(32'h5A, 8);
        push_field(32'd1, 32);
        push_field(32'hC3, 8);
        send_image(sb.header_cfg);

        // no header, all-ones magic
        apply_settings(16'd0, 16'hFFFF, 2'b11);
        push_field(32'h0000, 16);               // mismatch, then dropped bytes
        repeat (5) bits_q.push_back(1'b1);
        send_image(sb.header_cfg);
        push_field(32'hFFFF, 16);
        push_field(32'd2, 32);
        push_field(32'h00, 8);
        push_field(32'hFF, 8);
        push_field(32'd3, 32);
        push_field(32'hA5, 8);
        push_field(32'h5A, 8);
        push_field(32'hFF, 8);
        repeat (4) bits_q.push_back(1'($urandom()));
        send_image(sb.header_cfg);
        push_field(32'hFFFF, 16);               // negative lengths
        push_field(32'h8000_0000, 32);
        push_field(32'hFFFF_FFFF, 32);
        send_image(sb.header_cfg);
        push_field(32'hFFFF, 16);               // huge payload cut by a new image
        push_field(32'hFFFF_FFFF, 32);
        push_field(32'h7FFF_FFFF, 32);
        push_field(32'h81, 8);
        push_field(32'h7E, 8);
        send_image(sb.header_cfg);
        push_field(32'hFFFE, 16);               // one bit off
        send_image(sb.header_cfg);

        for (int p = 0; p < 6; p++)
        begin
            which = 2'b11;
            mw    = 16'($urandom());
            case (p)
                0: hdr = 16'd1;
                1: begin hdr = 16'd3; mw = 16'h0000; end
                2: begin hdr = 16'($urandom_range(0, 12)); which = 2'b01; end
                3: hdr = lsbsd_pkg::HEADER_BYTES_RST;
                4: begin hdr = 16'd0; mw = 16'hFFFF; end
                default: hdr = 16'($urandom_range(2, 20));
            endcase
            apply_settings(hdr, mw, which);
            goal = active_items + PHASE_ITEMS;
            while (active_items < goal)
                random_image();
        end

        // long header, one short frame, no idling
        apply_settings(16'd64, 16'($urandom()), 2'b11);
        force_quiet = 1'b1;
        push_field({16'd0, sb.magic_cfg}, 16);
        push_field(32'd1, 32);
        push_field($urandom(), 8);
        push_field(32'd2, 32);
        push_field($urandom(), 8);
        push_field($urandom(), 8);
        send_image(sb.header_cfg);
        force_quiet = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
